// ----- rtl/smdma_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smdma_pkg: shared types for the signed multiply / divide / modulo accumulator
// Item formats, operation codes and sequencer states used by the block.
// ----------------------------------------------------------------------------
package smdma_pkg;

  // Width of the operand and value fields on the ports.
  localparam int DATA_W = 64;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2,
    OP_MOD  = 2'd3
  } smdma_op_t;

  typedef struct packed {
    smdma_op_t                 opcode;
    logic signed [DATA_W-1:0]  operand;
    logic                      dead_branch;
  } smdma_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  value;
    logic                      error;
  } smdma_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEG_A,
    ST_NEG_B,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } smdma_state_t;

endpackage : smdma_pkg
`default_nettype wire

// ----- rtl/signed_mul_div_mod_accumulator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// signed_mul_div_mod_accumulator: iterative signed multiply / divide / modulo
// A WIDTH-bit accumulator for a left-associative chain of mul, div and mod.
// ----------------------------------------------------------------------------
// Usage notes.
// Items arrive on the req channel (req_valid / req_ready) and every item
// produces exactly one result item on the rsp channel (rsp_valid / rsp_ready).
// A load item sets the accumulator to the operand and clears the sticky
// error flag. Multiply keeps the low WIDTH bits of the product; divide and
// modulo truncate toward zero. A zero divisor gives 0 and sets the error
// flag unless the item is marked dead_branch. While the flag is set, every
// item other than a load leaves the state unchanged.
// A load, any item while the error flag is set and a zero divisor go
// straight to the output stage; a multiply first runs the shift-add steps,
// and a divide or modulo takes magnitudes, divides and fixes the sign.
// All arithmetic runs through one WIDTH+1 bit adder/subtractor: shift-add
// for multiply, restoring division one quotient bit a cycle, and separate
// cycles for taking magnitudes and fixing the sign. A new item is taken
// only once the last result has been moved to the output register.
// The result sits in an output register. If the receiver stalls, the next
// item is still accepted and computed; it then waits until the output
// register has been taken. Reset clears the accumulator and the error flag
// and empties the output register.
// ----------------------------------------------------------------------------
module signed_mul_div_mod_accumulator #(
  parameter int WIDTH = 64
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire smdma_pkg::smdma_req_t req,
  input  wire                        req_valid,
  output logic                       req_ready,
  output smdma_pkg::smdma_rsp_t      rsp,
  output logic                       rsp_valid,
  input  wire                        rsp_ready
);

  import smdma_pkg::*;

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  // Architectural state.
  logic [WIDTH-1:0]  acc, acc_next;
  logic              err, err_next;

  // Sequencer and working registers.
  smdma_state_t      state, state_next;
  smdma_op_t         op, op_next;
  logic [WIDTH-1:0]  x, x_next;      // multiplicand, or dividend/quotient shifter
  logic [WIDTH-1:0]  y, y_next;      // multiplier shifter, or divisor magnitude
  logic [WIDTH-1:0]  p, p_next;      // product, or partial remainder
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              neg_q, neg_q_next;
  logic              neg_r, neg_r_next;
  logic [WIDTH-1:0]  res, res_next;
  logic              res_err, res_err_next;

  // Output register.
  smdma_rsp_t        rsp_next;
  logic              rsp_valid_next;

  // The shared adder/subtractor.
  logic [WIDTH:0]    alu_a, alu_b, alu_sum;
  logic              alu_sub;

  logic [WIDTH:0]    shifted;
  logic [WIDTH-1:0]  fix_sel;
  logic              fix_neg;
  logic signed [WIDTH-1:0] res_s;

  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {{WIDTH{1'b0}}, alu_sub};
  assign shifted = {p, x[WIDTH-1]};
  assign fix_sel = (op == OP_MOD) ? p : x;
  assign fix_neg = (op == OP_MOD) ? neg_r : neg_q;
  assign res_s   = res;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    acc_next       = acc;
    err_next       = err;
    op_next        = op;
    x_next         = x;
    y_next         = y;
    p_next         = p;
    cnt_next       = cnt;
    neg_q_next     = neg_q;
    neg_r_next     = neg_r;
    res_next       = res;
    res_err_next   = res_err;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && !rsp_ready;
    alu_a          = '0;
    alu_b          = '0;
    alu_sub        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          op_next    = req.opcode;
          x_next     = acc;
          y_next     = req.operand[WIDTH-1:0];
          p_next     = '0;
          cnt_next   = CNT_W'(WIDTH - 1);
          neg_q_next = acc[WIDTH-1] ^ req.operand[WIDTH-1];
          neg_r_next = acc[WIDTH-1];
          res_err_next = err;
          if (req.opcode == OP_LOAD) begin
            res_next     = req.operand[WIDTH-1:0];
            res_err_next = 1'b0;
            state_next   = ST_OUT;
          end else if (err) begin
            res_next   = acc;
            state_next = ST_OUT;
          end else if (req.opcode == OP_MUL) begin
            state_next = ST_MUL;
          end else if (req.operand[WIDTH-1:0] == '0) begin
            // Division by zero: result 0, flag unless the branch is dead.
            res_next     = '0;
            res_err_next = !req.dead_branch;
            state_next   = ST_OUT;
          end else begin
            state_next = ST_NEG_A;
          end
        end
      end

      ST_NEG_A: begin
        alu_a   = '0;
        alu_b   = {1'b0, x};
        alu_sub = 1'b1;
        if (x[WIDTH-1]) begin
          x_next = alu_sum[WIDTH-1:0];
        end
        state_next = ST_NEG_B;
      end

      ST_NEG_B: begin
        alu_a   = '0;
        alu_b   = {1'b0, y};
        alu_sub = 1'b1;
        if (y[WIDTH-1]) begin
          y_next = alu_sum[WIDTH-1:0];
        end
        state_next = ST_DIV;
      end

      ST_MUL: begin
        alu_a   = {1'b0, p};
        alu_b   = {1'b0, x};
        alu_sub = 1'b0;
        if (y[0]) begin
          p_next = alu_sum[WIDTH-1:0];
        end
        x_next   = x << 1;
        y_next   = y >> 1;
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          res_next   = y[0] ? alu_sum[WIDTH-1:0] : p;
          state_next = ST_OUT;
        end
      end

      ST_DIV: begin
        // Restoring step: bring in the next dividend bit, try the divisor.
        alu_a   = shifted;
        alu_b   = {1'b0, y};
        alu_sub = 1'b1;
        if (!alu_sum[WIDTH]) begin
          p_next = alu_sum[WIDTH-1:0];
        end else begin
          p_next = shifted[WIDTH-1:0];
        end
        x_next   = {x[WIDTH-2:0], !alu_sum[WIDTH]};
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = ST_FIX;
        end
      end

      ST_FIX: begin
        alu_a   = '0;
        alu_b   = {1'b0, fix_sel};
        alu_sub = 1'b1;
        res_next   = fix_neg ? alu_sum[WIDTH-1:0] : fix_sel;
        state_next = ST_OUT;
      end

      ST_OUT: begin
        if (!rsp_valid || rsp_ready) begin
          acc_next       = res;
          err_next       = res_err;
          rsp_next.value = DATA_W'(res_s);
          rsp_next.error = res_err;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      acc       <= '0;
      err       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      acc       <= acc_next;
      err       <= err_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    x       <= x_next;
    y       <= y_next;
    p       <= p_next;
    cnt     <= cnt_next;
    neg_q   <= neg_q_next;
    neg_r   <= neg_r_next;
    res     <= res_next;
    res_err <= res_err_next;
    rsp     <= rsp_next;
  end

endmodule : signed_mul_div_mod_accumulator
`default_nettype wire

// ----- verif/signed_mul_div_mod_accumulator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_mul_div_mod_accumulator_tb: self-checking bench for the accumulator
// Drives load, multiply, divide and modulo items through the request channel.
// A local model of the accumulator and its sticky error flag predicts every
// result item, and each result is checked against the oldest prediction.
// Both channels stall at random, then the bench runs with no stalls at all.
// ----------------------------------------------------------------------------
module signed_mul_div_mod_accumulator_tb;
  import smdma_pkg::*;

  localparam int WIDTH = 64;
  localparam int CYCLE_LIMIT = 600000;
  // Longest latency of one item (divide or modulo) plus a margin.
  localparam int DRAIN_CYCLES = 80;

  localparam logic signed [63:0] MIN_VAL = -(64'sd1 <<< (WIDTH - 1));
  localparam logic signed [63:0] MAX_VAL = ~MIN_VAL;
  localparam logic signed [63:0] MINUS_ONE = -64'sd1;

  logic       clk;
  logic       rst;
  smdma_req_t req;
  logic       req_valid;
  logic       req_ready;
  smdma_rsp_t rsp;
  logic       rsp_valid;
  logic       rsp_ready;

  // Percentage of cycles in which the sender holds back and the receiver
  // refuses a result. They are changed between the phases of the run.
  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  int cycles;

  // Our own copy of the block's state, advanced as items are accepted.
  logic signed [63:0] acc_model;
  logic               err_model;
  smdma_rsp_t         pending_results[$];

  signed_mul_div_mod_accumulator #(
    .WIDTH(WIDTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .rsp      (rsp),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready)
  );

  always #2 clk = ~clk;

  // Keeps the low WIDTH bits and reads them as a signed WIDTH-bit number,
  // held sign-extended to 64 bits just as the ports carry it.
  function automatic logic signed [63:0] to_width(input logic [63:0] x);
    logic signed [63:0] shifted;
    shifted = x << (64 - WIDTH);
    return shifted >>> (64 - WIDTH);
  endfunction

  // Works out the result that one accepted item causes and queues it.
  // While the error flag is set only a load changes anything. A zero
  // divisor clears the accumulator and raises the flag unless the item is
  // a dead branch. The minimum divided by minus one is handled apart, as
  // native signed division would overflow there.
  task automatic advance_accumulator(input smdma_req_t it);
    logic signed [63:0] rhs;
    smdma_rsp_t         res;
    rhs = to_width(it.operand);
    if (it.opcode == OP_LOAD) begin
      acc_model = rhs;
      err_model = 1'b0;
    end else if (!err_model) begin
      if (it.opcode == OP_MUL) begin
        acc_model = to_width(acc_model * rhs);
      end else if (rhs == 64'sd0) begin
        acc_model = '0;
        if (!it.dead_branch) begin
          err_model = 1'b1;
        end
      end else if (acc_model == MIN_VAL && rhs == MINUS_ONE) begin
        acc_model = (it.opcode == OP_DIV) ? MIN_VAL : 64'sd0;
      end else if (it.opcode == OP_DIV) begin
        acc_model = to_width(acc_model / rhs);
      end else begin
        acc_model = to_width(acc_model % rhs);
      end
    end
    res.value = acc_model;
    res.error = err_model;
    pending_results.push_back(res);
  endtask

  // Presents one item and holds it until the block takes it. Valid is
  // dropped only during a random gap, so back-to-back items keep it high
  // and it is never lowered and raised within one time step.
  task automatic push_item(input smdma_op_t op, input logic signed [63:0] operand,
                           input logic dead);
    smdma_req_t it;
    it.opcode      = op;
    it.operand     = operand;
    it.dead_branch = dead;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    advance_accumulator(it);
  endtask

  // Operands lean towards the interesting corners: zero (a zero divisor),
  // plus and minus one, both extremes and small numbers that keep long
  // chains away from zero, with fully random words for the rest.
  function automatic logic signed [63:0] pick_operand();
    logic signed [63:0] small_val;
    small_val = 64'($urandom_range(40));
    case ($urandom_range(11))
      0:       return 64'sd0;
      1:       return 64'sd1;
      2:       return MINUS_ONE;
      3:       return MIN_VAL;
      4:       return MAX_VAL;
      5, 6, 7: return small_val - 64'sd20;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Result side: random back-pressure, and every accepted result item is
  // compared with the oldest prediction.
  always @(posedge clk) begin
    smdma_rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: value %0d error %0b", $time, rsp.value,
                   rsp.error);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (rsp.value !== want.value) begin
            $display("%0t value mismatch: expected %0d, actual %0d", $time,
                     want.value, rsp.value);
            errors++;
          end
          if (rsp.error !== want.error) begin
            $display("%0t error mismatch: expected %0b, actual %0b", $time,
                     want.error, rsp.error);
            errors++;
          end
        end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Start values at both ends of the range, and a dead-branch load, which
  // must behave as any other load.
  task automatic test_load_extremes();
    push_item(OP_LOAD, MAX_VAL, 1'b0);
    push_item(OP_LOAD, MIN_VAL, 1'b0);
    push_item(OP_LOAD, 64'sd0, 1'b1);
  endtask

  // Products that overflow keep only their low bits; the minimum times
  // minus one wraps back onto the minimum.
  task automatic test_multiply_wrap();
    push_item(OP_LOAD, MAX_VAL, 1'b0);
    push_item(OP_MUL, 64'sd2, 1'b0);
    push_item(OP_MUL, MINUS_ONE, 1'b1);
    push_item(OP_LOAD, MIN_VAL, 1'b0);
    push_item(OP_MUL, MINUS_ONE, 1'b0);
  endtask

  // Quotients truncate toward zero and remainders follow the dividend.
  task automatic test_divide_modulo_signs();
    push_item(OP_LOAD, -64'sd7, 1'b0);
    push_item(OP_DIV, 64'sd2, 1'b0);
    push_item(OP_MOD, -64'sd2, 1'b0);
    push_item(OP_LOAD, 64'sd7, 1'b0);
    push_item(OP_DIV, -64'sd2, 1'b0);
    push_item(OP_MOD, 64'sd2, 1'b0);
  endtask

  // The minimum divided by minus one stays at the minimum; its remainder
  // is zero.
  task automatic test_min_by_minus_one();
    push_item(OP_LOAD, MIN_VAL, 1'b0);
    push_item(OP_DIV, MINUS_ONE, 1'b0);
    push_item(OP_MOD, MINUS_ONE, 1'b0);
  endtask

  // A zero divisor on a dead branch clears the value but not the flag.
  // Otherwise the flag sticks, later operations are ignored, and only a
  // load clears it again.
  task automatic test_zero_divisor();
    push_item(OP_LOAD, 64'sd5, 1'b0);
    push_item(OP_DIV, 64'sd0, 1'b1);
    push_item(OP_LOAD, 64'sd5, 1'b0);
    push_item(OP_MOD, 64'sd0, 1'b0);
    push_item(OP_MUL, 64'sd3, 1'b0);
    push_item(OP_DIV, 64'sd0, 1'b1);
    push_item(OP_LOAD, 64'sd9, 1'b0);
  endtask

  // Random chains: each starts with a load and goes on with a few random
  // operations. Zero divisors turn up often enough that many chains end in
  // the error state and the ignored operations are exercised too.
  task automatic test_random_chains(input int n_items, input int send_pct,
                                    input int recv_pct);
    int sent;
    int chain_len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      push_item(OP_LOAD, pick_operand(), 1'($urandom_range(1)));
      sent++;
      chain_len = $urandom_range(1, 8);
      repeat (chain_len) begin
        push_item(smdma_op_t'($urandom_range(1, 3)), pick_operand(),
                  1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    req           = '0;
    req_valid     = 1'b0;
    errors        = 0;
    acc_model     = '0;
    err_model     = 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 70;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The directed items run under the first stall pattern.
    test_load_extremes();
    test_multiply_wrap();
    test_divide_modulo_signs();
    test_min_by_minus_one();
    test_zero_divisor();

    test_random_chains(220, 29, 70);
    test_random_chains(220, 70, 29);
    test_random_chains(210, 0, 0);
    req_valid <= 1'b0;

    // Let every outstanding result arrive, then watch a little longer for
    // anything the block should not have produced.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/smdma_pkg.sv
rtl/signed_mul_div_mod_accumulator.sv
verif/signed_mul_div_mod_accumulator_tb.sv
